@@ rtl/twl_pkg.sv @@
// ----------------------------------------------------------------------------
// twl_pkg: shared types and codes for the two-class waiting list
// Command and status codes, fixed field widths and the controller state type.
// ----------------------------------------------------------------------------
package twl_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned AGE_W    = 8;

  // Command codes carried on the input tuser
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SERVE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd3;

  // Status codes carried on the output tuser
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SERVE,
    ST_WALK,
    ST_RELEASE,
    ST_DONE
  } state_e;

endpackage

@@ rtl/two_class_waiting_list.sv @@
// ----------------------------------------------------------------------------
// two_class_waiting_list: bounded ordered waiting list with keyed lookup
// Linked list of up to DEPTH entries kept in slot memories, with a free chain.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the slave stream: tuser carries the command (insert,
//   serve front, find by key, delete by key), tdata the key, age, reason and
//   urgent flag. Each command yields exactly one result transaction on the
//   master stream: tuser carries the status, tdata the entry that was served,
//   found or deleted, and the entry count after the command.
//   After accept, an insert passes through the insert state and a serve
//   through the serve state before the done state; a serve or lookup on an
//   empty list and an insert on a full list go straight to done. Find and
//   delete walk the list from the front until the key matches or all entries
//   have been read, and a delete that hits then puts its slot on the free
//   chain in the release state. The walk follows the link memory one slot
//   per cycle, as each next pointer comes from a registered read. One
//   command is in flight at a time; the next is accepted in the cycle after
//   the result has moved into the output register. The output register
//   holds the result while the receiver stalls. After reset the list is
//   empty and never-used slots are handed out in order by a fill counter.
// ----------------------------------------------------------------------------
module two_class_waiting_list #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned KEY_BITS    = 32,
  parameter int unsigned REASON_BITS = 16,
  localparam int unsigned AW    = $clog2(DEPTH),
  localparam int unsigned CW    = $clog2(DEPTH + 1),
  localparam int unsigned PW    = KEY_BITS + twl_pkg::AGE_W + REASON_BITS + 1,
  localparam int unsigned IN_W  = ((PW + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((PW + CW + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // key, age, reason_code, urgent, zero fill
  input  logic [IN_W-1:0]              s_axis_tdata_i,
  // cmd
  input  logic [twl_pkg::CMD_W-1:0]    s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // found_key, found_age, found_reason, found_urgent, entry_count, zero fill
  output logic [OUT_W-1:0]             m_axis_tdata_o,
  // status
  output logic [twl_pkg::STATUS_W-1:0] m_axis_tuser_o
);

  logic                         res_valid, res_ready;
  logic [twl_pkg::STATUS_W-1:0] res_status;
  logic [KEY_BITS-1:0]          res_key;
  logic [twl_pkg::AGE_W-1:0]    res_age;
  logic [REASON_BITS-1:0]       res_reason;
  logic                         res_urgent;
  logic [CW-1:0]                res_count;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          pay_we, lnk_we;
  logic [AW-1:0] pay_waddr, lnk_waddr, lnk_wdata, lnk_rdata;
  logic [PW-1:0] pay_wdata, pay_rdata;

  logic                         out_valid_q;
  logic [OUT_W-1:0]             out_data_q;
  logic [twl_pkg::STATUS_W-1:0] out_user_q;

  twl_ctrl #(
    .DEPTH       (DEPTH),
    .KEY_BITS    (KEY_BITS),
    .REASON_BITS (REASON_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_cmd_i     (s_axis_tuser_i),
    .in_key_i     (s_axis_tdata_i[KEY_BITS-1:0]),
    .in_age_i     (s_axis_tdata_i[KEY_BITS +: twl_pkg::AGE_W]),
    .in_reason_i  (s_axis_tdata_i[KEY_BITS+twl_pkg::AGE_W +: REASON_BITS]),
    .in_urgent_i  (s_axis_tdata_i[PW-1]),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_status_o (res_status),
    .res_key_o    (res_key),
    .res_age_o    (res_age),
    .res_reason_o (res_reason),
    .res_urgent_o (res_urgent),
    .res_count_o  (res_count),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .pay_we_o     (pay_we),
    .pay_waddr_o  (pay_waddr),
    .pay_wdata_o  (pay_wdata),
    .pay_rdata_i  (pay_rdata),
    .lnk_we_o     (lnk_we),
    .lnk_waddr_o  (lnk_waddr),
    .lnk_wdata_o  (lnk_wdata),
    .lnk_rdata_i  (lnk_rdata)
  );

  twl_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH)
  ) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (pay_waddr),
    .wdata_i (pay_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (pay_rdata)
  );

  twl_ram #(
    .WIDTH (AW),
    .DEPTH (DEPTH)
  ) u_lnk_ram (
    .clk_i   (clk_i),
    .we_i    (lnk_we),
    .waddr_i (lnk_waddr),
    .wdata_i (lnk_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (lnk_rdata)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= OUT_W'({res_count, res_urgent, res_reason, res_age, res_key});
      out_user_q <= res_status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

@@ rtl/twl_ram.sv @@
// ----------------------------------------------------------------------------
// twl_ram: simple dual-port synchronous memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module twl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/twl_ctrl.sv @@
// ----------------------------------------------------------------------------
// twl_ctrl: list sequencer for the two-class waiting list
// Holds head, tail, free-chain and count registers, and drives the slot
// payload and link memories one access per cycle for each command.
// ----------------------------------------------------------------------------
module twl_ctrl #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned KEY_BITS    = 32,
  parameter int unsigned REASON_BITS = 16,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1),
  localparam int unsigned PW = KEY_BITS + twl_pkg::AGE_W + REASON_BITS + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command transaction
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [twl_pkg::CMD_W-1:0]     in_cmd_i,
  input  logic [KEY_BITS-1:0]           in_key_i,
  input  logic [twl_pkg::AGE_W-1:0]     in_age_i,
  input  logic [REASON_BITS-1:0]        in_reason_i,
  input  logic                          in_urgent_i,
  // result transaction
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [twl_pkg::STATUS_W-1:0]  res_status_o,
  output logic [KEY_BITS-1:0]           res_key_o,
  output logic [twl_pkg::AGE_W-1:0]     res_age_o,
  output logic [REASON_BITS-1:0]        res_reason_o,
  output logic                          res_urgent_o,
  output logic [CW-1:0]                 res_count_o,
  // shared read address for both memories
  output logic                          rd_en_o,
  output logic [AW-1:0]                 rd_addr_o,
  // payload memory
  output logic                          pay_we_o,
  output logic [AW-1:0]                 pay_waddr_o,
  output logic [PW-1:0]                 pay_wdata_o,
  input  logic [PW-1:0]                 pay_rdata_i,
  // link memory
  output logic                          lnk_we_o,
  output logic [AW-1:0]                 lnk_waddr_o,
  output logic [AW-1:0]                 lnk_wdata_o,
  input  logic [AW-1:0]                 lnk_rdata_i
);

  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  twl_pkg::state_e state_q, state_d;

  // list control registers
  logic [AW-1:0] head_q, tail_q, free_head_q;
  logic [CW-1:0] used_q, rel_cnt_q, fresh_q;
  logic [AW-1:0] cur_q, prev_q, slot_q;
  logic [CW-1:0] step_q;

  // latched command
  logic [twl_pkg::CMD_W-1:0] cmd_q;
  logic [KEY_BITS-1:0]       key_q;
  logic [twl_pkg::AGE_W-1:0] age_q;
  logic [REASON_BITS-1:0]    reason_q;
  logic                      urgent_q;

  // result holding registers
  logic [twl_pkg::STATUS_W-1:0] status_q;
  logic [KEY_BITS-1:0]          rkey_q;
  logic [twl_pkg::AGE_W-1:0]    rage_q;
  logic [REASON_BITS-1:0]       rreason_q;
  logic                         rurgent_q;

  logic                      accept;
  logic                      key_hit;
  logic                      last_step;
  logic [KEY_BITS-1:0]       pay_key;
  logic [twl_pkg::AGE_W-1:0] pay_age;
  logic [REASON_BITS-1:0]    pay_reason;
  logic                      pay_urgent;

  assign accept = in_valid_i && in_ready_o;
  assign {pay_urgent, pay_reason, pay_age, pay_key} = pay_rdata_i;
  assign key_hit   = (pay_key == key_q);
  assign last_step = ((step_q + 1'b1) == used_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      twl_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_cmd_i)
            twl_pkg::CMD_INSERT:
              state_d = (used_q == FULL_COUNT) ? twl_pkg::ST_DONE : twl_pkg::ST_INSERT;
            twl_pkg::CMD_SERVE:
              state_d = (used_q == '0) ? twl_pkg::ST_DONE : twl_pkg::ST_SERVE;
            default:
              state_d = (used_q == '0) ? twl_pkg::ST_DONE : twl_pkg::ST_WALK;
          endcase
        end
      end
      twl_pkg::ST_INSERT:  state_d = twl_pkg::ST_DONE;
      twl_pkg::ST_SERVE:   state_d = twl_pkg::ST_DONE;
      twl_pkg::ST_WALK: begin
        if (key_hit) begin
          state_d = (cmd_q == twl_pkg::CMD_DELETE) ? twl_pkg::ST_RELEASE : twl_pkg::ST_DONE;
        end else if (last_step) begin
          state_d = twl_pkg::ST_DONE;
        end
      end
      twl_pkg::ST_RELEASE: state_d = twl_pkg::ST_DONE;
      twl_pkg::ST_DONE: begin
        if (res_ready_i) begin
          state_d = twl_pkg::ST_IDLE;
        end
      end
      default: state_d = twl_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshakes and memory port controls
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    rd_en_o     = 1'b0;
    rd_addr_o   = head_q;
    pay_we_o    = 1'b0;
    pay_waddr_o = slot_q;
    pay_wdata_o = {urgent_q, reason_q, age_q, key_q};
    lnk_we_o    = 1'b0;
    lnk_waddr_o = slot_q;
    lnk_wdata_o = head_q;
    case (state_q)
      twl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        rd_en_o    = 1'b1;
        rd_addr_o  = (in_cmd_i == twl_pkg::CMD_INSERT) ? free_head_q : head_q;
      end
      twl_pkg::ST_INSERT: begin
        pay_we_o = 1'b1;
        if (urgent_q) begin
          // new front entry points at the old head
          lnk_we_o    = 1'b1;
          lnk_waddr_o = slot_q;
          lnk_wdata_o = head_q;
        end else if (used_q != '0) begin
          // old tail points at the new entry
          lnk_we_o    = 1'b1;
          lnk_waddr_o = tail_q;
          lnk_wdata_o = slot_q;
        end
      end
      twl_pkg::ST_SERVE: begin
        // push the served slot onto the free chain
        lnk_we_o    = 1'b1;
        lnk_waddr_o = head_q;
        lnk_wdata_o = free_head_q;
      end
      twl_pkg::ST_WALK: begin
        if (key_hit) begin
          // bypass the hit entry unless it is the head
          if (cmd_q == twl_pkg::CMD_DELETE && step_q != '0) begin
            lnk_we_o    = 1'b1;
            lnk_waddr_o = prev_q;
            lnk_wdata_o = lnk_rdata_i;
          end
        end else if (!last_step) begin
          rd_en_o   = 1'b1;
          rd_addr_o = lnk_rdata_i;
        end
      end
      twl_pkg::ST_RELEASE: begin
        lnk_we_o    = 1'b1;
        lnk_waddr_o = cur_q;
        lnk_wdata_o = free_head_q;
      end
      twl_pkg::ST_DONE: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= twl_pkg::ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      free_head_q <= '0;
      used_q      <= '0;
      rel_cnt_q   <= '0;
      fresh_q     <= '0;
      step_q      <= '0;
      cur_q       <= '0;
      prev_q      <= '0;
      slot_q      <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        twl_pkg::ST_IDLE: begin
          cur_q  <= head_q;
          prev_q <= head_q;
          step_q <= '0;
          // take a released slot first, otherwise a never-used one
          slot_q <= (rel_cnt_q != '0) ? free_head_q : fresh_q[AW-1:0];
        end
        twl_pkg::ST_INSERT: begin
          if (rel_cnt_q != '0) begin
            free_head_q <= lnk_rdata_i;
            rel_cnt_q   <= rel_cnt_q - 1'b1;
          end else begin
            fresh_q <= fresh_q + 1'b1;
          end
          if (urgent_q) begin
            head_q <= slot_q;
            if (used_q == '0) begin
              tail_q <= slot_q;
            end
          end else begin
            if (used_q == '0) begin
              head_q <= slot_q;
            end
            tail_q <= slot_q;
          end
          used_q <= used_q + 1'b1;
        end
        twl_pkg::ST_SERVE: begin
          head_q      <= lnk_rdata_i;
          free_head_q <= head_q;
          rel_cnt_q   <= rel_cnt_q + 1'b1;
          used_q      <= used_q - 1'b1;
        end
        twl_pkg::ST_WALK: begin
          if (key_hit) begin
            if (cmd_q == twl_pkg::CMD_DELETE) begin
              if (step_q == '0) begin
                head_q <= lnk_rdata_i;
              end
              if (cur_q == tail_q) begin
                tail_q <= prev_q;
              end
              used_q <= used_q - 1'b1;
            end
          end else begin
            prev_q <= cur_q;
            cur_q  <= lnk_rdata_i;
            step_q <= step_q + 1'b1;
          end
        end
        twl_pkg::ST_RELEASE: begin
          free_head_q <= cur_q;
          rel_cnt_q   <= rel_cnt_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Latch the command and build the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= in_cmd_i;
      key_q     <= in_key_i;
      age_q     <= in_age_i;
      reason_q  <= in_reason_i;
      urgent_q  <= in_urgent_i;
      rkey_q    <= '0;
      rage_q    <= '0;
      rreason_q <= '0;
      rurgent_q <= 1'b0;
      if (in_cmd_i == twl_pkg::CMD_INSERT) begin
        status_q <= (used_q == FULL_COUNT) ? twl_pkg::STATUS_FULL : twl_pkg::STATUS_OK;
      end else begin
        status_q <= (used_q == '0) ? twl_pkg::STATUS_MISS : twl_pkg::STATUS_OK;
      end
    end else if (state_q == twl_pkg::ST_SERVE ||
                 (state_q == twl_pkg::ST_WALK && key_hit)) begin
      rkey_q    <= pay_key;
      rage_q    <= pay_age;
      rreason_q <= pay_reason;
      rurgent_q <= pay_urgent;
    end else if (state_q == twl_pkg::ST_WALK && last_step) begin
      status_q <= twl_pkg::STATUS_MISS;
    end
  end

  assign res_status_o = status_q;
  assign res_key_o    = rkey_q;
  assign res_age_o    = rage_q;
  assign res_reason_o = rreason_q;
  assign res_urgent_o = rurgent_q;
  assign res_count_o  = used_q;

endmodule

@@ tb/sv/two_class_waiting_list_tb.sv @@
// ----------------------------------------------------------------------------
// two_class_waiting_list_tb: self-checking bench for the two-class waiting list
// Drives insert, serve, find and delete commands on the input stream. A queue-based
// predictor of the ordered list computes each expected result but for typed rows,
// and every result transaction is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module two_class_waiting_list_tb;

  localparam int unsigned LIST_DEPTH  = 64;
  localparam int unsigned MAX_CYCLES  = 1000000;
  localparam int unsigned BLOCK_ITEMS = 100;

  typedef struct packed {
    logic [twl_pkg::CMD_W-1:0] cmd;
    logic [31:0]               key;
    logic [7:0]                age;
    logic [15:0]               reason;
    logic                      urgent;
  } command_t;

  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  age;
    logic [15:0] reason;
    logic        urgent;
  } entry_t;

  typedef struct packed {
    logic [twl_pkg::STATUS_W-1:0] status;
    logic [31:0]                  key;
    logic [7:0]                   age;
    logic [15:0]                  reason;
    logic                         urgent;
    logic [6:0]                   entries;
  } answer_t;

  typedef struct packed {
    command_t item;
    logic     typed;
    answer_t  answer;
  } script_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  // key, age, reason_code, urgent, zero fill
  logic [63:0] s_axis_tdata_i;
  // cmd
  logic [twl_pkg::CMD_W-1:0] s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // found_key, found_age, found_reason, found_urgent, entry_count, zero fill
  logic [63:0] m_axis_tdata_o;
  // status
  logic [twl_pkg::STATUS_W-1:0] m_axis_tuser_o;

  // predictor state: the list in service order, front first
  entry_t      waiting_list[$];
  answer_t     pending_answers[$];
  script_row_t script_rows[$];
  logic [31:0] key_pool[16];

  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned results_checked;
  int unsigned cmd_seen[4];
  int unsigned full_drops;
  int unsigned misses;
  int unsigned peak_entries;

  two_class_waiting_list #(
    .DEPTH      (LIST_DEPTH),
    .KEY_BITS   (32),
    .REASON_BITS(16)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= MAX_CYCLES) begin
        $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
                 cycle_count, pending_answers.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Compute the result of one command and advance the list
  function automatic answer_t apply_to_list(input command_t c);
    answer_t a;
    entry_t  e;
    int      hit;
    a = '0;
    hit = -1;
    case (c.cmd)
      twl_pkg::CMD_INSERT: begin
        if (waiting_list.size() >= LIST_DEPTH) begin
          a.status = twl_pkg::STATUS_FULL;
        end else begin
          e.key = c.key;
          e.age = c.age;
          e.reason = c.reason;
          e.urgent = c.urgent;
          if (c.urgent) waiting_list.push_front(e);
          else waiting_list.push_back(e);
          a.status = twl_pkg::STATUS_OK;
        end
      end
      twl_pkg::CMD_SERVE: begin
        if (waiting_list.size() == 0) begin
          a.status = twl_pkg::STATUS_MISS;
        end else begin
          e = waiting_list.pop_front();
          a.status = twl_pkg::STATUS_OK;
          {a.key, a.age, a.reason, a.urgent} = e;
        end
      end
      default: begin
        for (int i = 0; i < waiting_list.size(); i++) begin
          if (hit < 0 && waiting_list[i].key == c.key) hit = i;
        end
        if (hit < 0) begin
          a.status = twl_pkg::STATUS_MISS;
        end else begin
          a.status = twl_pkg::STATUS_OK;
          {a.key, a.age, a.reason, a.urgent} = waiting_list[hit];
          if (c.cmd == twl_pkg::CMD_DELETE) waiting_list.delete(hit);
        end
      end
    endcase
    a.entries = 7'(waiting_list.size());
    return a;
  endfunction

  // Present one command, hold it until accepted, then record its expectation
  task automatic issue_command(input command_t c, input logic typed, input answer_t typed_ans);
    answer_t a;
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= c.cmd;
    s_axis_tdata_i  <= {7'd0, c.urgent, c.reason, c.age, c.key};
    forever begin
      @(posedge clk_i);
      if (s_axis_tready_o) break;
    end
    a = apply_to_list(c);
    if (typed) a = typed_ans;
    pending_answers.push_back(a);
    cmd_seen[c.cmd]++;
    if (a.status == twl_pkg::STATUS_FULL) full_drops++;
    if (a.status == twl_pkg::STATUS_MISS) misses++;
    if (a.entries > peak_entries) peak_entries = a.entries;
  endtask

  // Append a directed row; typed rows carry a status and count read off by hand
  task automatic add_row(input logic [twl_pkg::CMD_W-1:0] cmd, input logic [31:0] key,
                         input logic [7:0] age, input logic [15:0] reason, input logic urgent,
                         input logic typed, input logic [twl_pkg::STATUS_W-1:0] status,
                         input logic [6:0] entries);
    script_row_t r;
    r = '0;
    r.item = '{cmd: cmd, key: key, age: age, reason: reason, urgent: urgent};
    r.typed = typed;
    r.answer.status = status;
    r.answer.entries = entries;
    script_rows.push_back(r);
  endtask

  // Draw a random command, biased toward inserts by insert_pct
  function automatic command_t random_command(input int unsigned insert_pct);
    command_t    c;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < insert_pct) c.cmd = twl_pkg::CMD_INSERT;
    else begin
      case ($urandom_range(2))
        0: c.cmd = twl_pkg::CMD_SERVE;
        1: c.cmd = twl_pkg::CMD_FIND;
        default: c.cmd = twl_pkg::CMD_DELETE;
      endcase
    end
    if ($urandom_range(99) < 15) c.key = $urandom;
    else c.key = key_pool[$urandom_range(15)];
    // aim most lookups at a key that is in the list, anywhere along it
    if ((c.cmd == twl_pkg::CMD_FIND || c.cmd == twl_pkg::CMD_DELETE) &&
        waiting_list.size() != 0 && $urandom_range(99) < 70) begin
      c.key = waiting_list[$urandom_range(waiting_list.size() - 1)].key;
    end
    c.age = 8'($urandom_range(255));
    c.reason = 16'($urandom);
    c.urgent = 1'($urandom);
    return c;
  endfunction

  // Compare one field and report a mismatch
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Check each result transaction against the oldest expectation
  always @(posedge clk_i) begin
    answer_t want;
    answer_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.status  = m_axis_tuser_o;
      got.key     = m_axis_tdata_o[31:0];
      got.age     = m_axis_tdata_o[39:32];
      got.reason  = m_axis_tdata_o[55:40];
      got.urgent  = m_axis_tdata_o[56];
      got.entries = m_axis_tdata_o[63:57];
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        error_count++;
      end else begin
        want = pending_answers.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("found_key", want.key, got.key);
        check_field("found_age", 32'(want.age), 32'(got.age));
        check_field("found_reason", 32'(want.reason), 32'(got.reason));
        check_field("found_urgent", 32'(want.urgent), 32'(got.urgent));
        check_field("entry_count", 32'(want.entries), 32'(got.entries));
        results_checked++;
      end
    end
  end

  // Stall the result stream at random
  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      m_axis_tready_i <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Main sequence
  initial begin
    int unsigned insert_bias[5];
    command_t    c;
    script_row_t r;
    s_axis_tvalid_i   = 1'b0;
    s_axis_tdata_i    = '0;
    s_axis_tuser_i    = twl_pkg::CMD_INSERT;
    rst_ni            = 1'b0;
    sender_idle_pct   = 19;
    receiver_idle_pct = 80;
    error_count       = 0;
    results_checked   = 0;
    full_drops        = 0;
    misses            = 0;
    peak_entries      = 0;
    cmd_seen          = '{default: 0};
    insert_bias       = '{85, 40, 15, 65, 90};

    // small key pool so lookups hit, with both key extremes in it
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 16; i++) key_pool[i] = $urandom;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty list, field extremes, both insert ends, head/middle/tail deletes
    add_row(twl_pkg::CMD_SERVE, 32'h0, 8'd0, 16'h0, 1'b0,
            1'b1, twl_pkg::STATUS_MISS, 7'd0);
    add_row(twl_pkg::CMD_FIND, 32'h0, 8'd0, 16'h0, 1'b0,
            1'b1, twl_pkg::STATUS_MISS, 7'd0);
    add_row(twl_pkg::CMD_DELETE, 32'hFFFF_FFFF, 8'd0, 16'h0, 1'b0,
            1'b1, twl_pkg::STATUS_MISS, 7'd0);
    add_row(twl_pkg::CMD_INSERT, 32'h0, 8'd1, 16'h0, 1'b0,
            1'b1, twl_pkg::STATUS_OK, 7'd1);
    add_row(twl_pkg::CMD_INSERT, 32'hFFFF_FFFF, 8'd255, 16'hFFFF, 1'b0,
            1'b1, twl_pkg::STATUS_OK, 7'd2);
    add_row(twl_pkg::CMD_INSERT, 32'hA5A5_A5A5, 8'd0, 16'h8001, 1'b1,
            1'b1, twl_pkg::STATUS_OK, 7'd3);
    add_row(twl_pkg::CMD_INSERT, 32'h1234_5678, 8'h7F, 16'h1234, 1'b1,
            1'b1, twl_pkg::STATUS_OK, 7'd4);
    add_row(twl_pkg::CMD_FIND, 32'hFFFF_FFFF, 8'd0, 16'h0, 1'b0,
            1'b0, twl_pkg::STATUS_OK, 7'd0);
    add_row(twl_pkg::CMD_FIND, 32'h0, 8'd0, 16'h0, 1'b0,
            1'b0, twl_pkg::STATUS_OK, 7'd0);
    add_row(twl_pkg::CMD_FIND, 32'h5, 8'd0, 16'h0, 1'b0,
            1'b1, twl_pkg::STATUS_MISS, 7'd4);
    add_row(twl_pkg::CMD_INSERT, 32'h0, 8'd2, 16'h5A5A, 1'b0,
            1'b1, twl_pkg::STATUS_OK, 7'd5);
    add_row(twl_pkg::CMD_DELETE, 32'h0, 8'd0, 16'h0, 1'b0,
            1'b0, twl_pkg::STATUS_OK, 7'd0);
    add_row(twl_pkg::CMD_DELETE, 32'h0, 8'd0, 16'h0, 1'b0,
            1'b0, twl_pkg::STATUS_OK, 7'd0);
    add_row(twl_pkg::CMD_DELETE, 32'h1234_5678, 8'd0, 16'h0, 1'b0,
            1'b0, twl_pkg::STATUS_OK, 7'd0);
    add_row(twl_pkg::CMD_SERVE, 32'h0, 8'd0, 16'h0, 1'b0,
            1'b0, twl_pkg::STATUS_OK, 7'd0);
    add_row(twl_pkg::CMD_SERVE, 32'h0, 8'd0, 16'h0, 1'b0,
            1'b0, twl_pkg::STATUS_OK, 7'd0);
    add_row(twl_pkg::CMD_SERVE, 32'h0, 8'd0, 16'h0, 1'b0,
            1'b1, twl_pkg::STATUS_MISS, 7'd0);
    add_row(twl_pkg::CMD_INSERT, 32'h77, 8'd3, 16'h0077, 1'b1,
            1'b1, twl_pkg::STATUS_OK, 7'd1);
    add_row(twl_pkg::CMD_INSERT, 32'h88, 8'd4, 16'h0088, 1'b0,
            1'b1, twl_pkg::STATUS_OK, 7'd2);
    add_row(twl_pkg::CMD_DELETE, 32'h88, 8'd0, 16'h0, 1'b0,
            1'b0, twl_pkg::STATUS_OK, 7'd0);
    add_row(twl_pkg::CMD_INSERT, 32'h99, 8'd5, 16'h0099, 1'b0,
            1'b1, twl_pkg::STATUS_OK, 7'd2);
    add_row(twl_pkg::CMD_SERVE, 32'h0, 8'd0, 16'h0, 1'b0,
            1'b0, twl_pkg::STATUS_OK, 7'd0);
    add_row(twl_pkg::CMD_SERVE, 32'h0, 8'd0, 16'h0, 1'b0,
            1'b0, twl_pkg::STATUS_OK, 7'd0);
    add_row(twl_pkg::CMD_FIND, 32'h77, 8'd0, 16'h0, 1'b0,
            1'b1, twl_pkg::STATUS_MISS, 7'd0);

    foreach (script_rows[i]) begin
      r = script_rows[i];
      issue_command(r.item, r.typed, r.answer);
    end

    // random: three idle profiles, each a run of fill and drain blocks
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 19;
          receiver_idle_pct = 80;
        end
        1: begin
          sender_idle_pct = 80;
          receiver_idle_pct = 19;
        end
        default: begin
          sender_idle_pct = 0;
          receiver_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < 5; blk++) begin
        for (int n = 0; n < BLOCK_ITEMS; n++) begin
          c = random_command(insert_bias[blk]);
          issue_command(c, 1'b0, '0);
        end
      end
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    // drain the outstanding results, then watch for strays
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (LIST_DEPTH + 8) @(posedge clk_i);

    $display("Checked %0d results: %0d insert, %0d serve, %0d find, %0d delete commands.",
             results_checked, cmd_seen[twl_pkg::CMD_INSERT],
             cmd_seen[twl_pkg::CMD_SERVE], cmd_seen[twl_pkg::CMD_FIND],
             cmd_seen[twl_pkg::CMD_DELETE]);
    $display("Saw %0d inserts dropped on a full list, %0d misses, peak of %0d entries.",
             full_drops, misses, peak_entries);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
